>>> rtl/core/tcsr_pkg.sv
`default_nettype none

package tcsr_pkg;

    typedef enum logic [1:0] {
        ST_STARTUP = 2'd0,
        ST_RUNNING = 2'd1,
        ST_TIMEOUT = 2'd2,
        ST_DONE    = 2'd3
    } cycle_status_t;

    typedef enum logic [2:0] {
        REG_TARGET_CURRENT   = 3'd0,
        REG_MAX_CURRENT      = 3'd1,
        REG_TARGET_VOLTAGE   = 3'd2,
        REG_HYSTERESIS       = 3'd3,
        REG_STEP             = 3'd4,
        REG_INITIAL_SETPOINT = 3'd5,
        REG_STARTUP          = 3'd6,
        REG_TIMEOUT          = 3'd7
    } reg_index_t;

    localparam int unsigned ADDR_W = 5;

    localparam logic [15:0] RST_TARGET_CURRENT   = 16'd100;
    localparam logic [15:0] RST_MAX_CURRENT      = 16'd2000;
    localparam logic [15:0] RST_TARGET_VOLTAGE   = 16'd14400;
    localparam logic [15:0] RST_HYSTERESIS       = 16'd50;
    localparam logic [15:0] RST_STEP             = 16'd10;
    localparam logic [15:0] RST_INITIAL_SETPOINT = 16'd13800;
    localparam logic [31:0] RST_STARTUP          = 32'd5000;
    localparam logic [31:0] RST_TIMEOUT          = 32'd86400000;

    typedef struct packed {
        logic [15:0] charge_current_ma;
        logic [15:0] battery_voltage_mv;
        logic [31:0] elapsed_ms;
    } in_item_t;

    typedef struct packed {
        cycle_status_t cycle_status;
        logic [15:0]   setpoint_mv;
        logic          setpoint_written;
        logic          regulator_on;
    } out_item_t;

    typedef struct packed {
        logic [15:0] target_current_ma;
        logic [15:0] max_current_ma;
        logic [15:0] target_voltage_mv;
        logic [15:0] hysteresis_mv;
        logic [15:0] step_mv;
        logic [31:0] startup_ms;
        logic [31:0] timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic        load;
        logic [15:0] value;
    } sp_load_t;

endpackage

`default_nettype wire

>>> rtl/core/tcsr_cfg_regs.sv
`default_nettype none

module tcsr_cfg_regs (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tcsr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output tcsr_pkg::cfg_t                   cfg,
    output tcsr_pkg::sp_load_t               sp_load
);

    tcsr_pkg::cfg_t     cfg_reg;
    logic [15:0]        init_sp_reg;
    logic               wr_en;
    tcsr_pkg::reg_index_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = tcsr_pkg::reg_index_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_current_ma <= tcsr_pkg::RST_TARGET_CURRENT;
            cfg_reg.max_current_ma    <= tcsr_pkg::RST_MAX_CURRENT;
            cfg_reg.target_voltage_mv <= tcsr_pkg::RST_TARGET_VOLTAGE;
            cfg_reg.hysteresis_mv     <= tcsr_pkg::RST_HYSTERESIS;
            cfg_reg.step_mv           <= tcsr_pkg::RST_STEP;
            cfg_reg.startup_ms        <= tcsr_pkg::RST_STARTUP;
            cfg_reg.timeout_ms        <= tcsr_pkg::RST_TIMEOUT;
            init_sp_reg               <= tcsr_pkg::RST_INITIAL_SETPOINT;
        end else if (wr_en) begin
            case (idx)
                tcsr_pkg::REG_TARGET_CURRENT:   cfg_reg.target_current_ma <= pwdata[15:0];
                tcsr_pkg::REG_MAX_CURRENT:      cfg_reg.max_current_ma    <= pwdata[15:0];
                tcsr_pkg::REG_TARGET_VOLTAGE:   cfg_reg.target_voltage_mv <= pwdata[15:0];
                tcsr_pkg::REG_HYSTERESIS:       cfg_reg.hysteresis_mv     <= pwdata[15:0];
                tcsr_pkg::REG_STEP:             cfg_reg.step_mv           <= pwdata[15:0];
                tcsr_pkg::REG_INITIAL_SETPOINT: init_sp_reg               <= pwdata[15:0];
                tcsr_pkg::REG_STARTUP:          cfg_reg.startup_ms        <= pwdata;
                tcsr_pkg::REG_TIMEOUT:          cfg_reg.timeout_ms        <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            tcsr_pkg::REG_TARGET_CURRENT:   prdata = {16'd0, cfg_reg.target_current_ma};
            tcsr_pkg::REG_MAX_CURRENT:      prdata = {16'd0, cfg_reg.max_current_ma};
            tcsr_pkg::REG_TARGET_VOLTAGE:   prdata = {16'd0, cfg_reg.target_voltage_mv};
            tcsr_pkg::REG_HYSTERESIS:       prdata = {16'd0, cfg_reg.hysteresis_mv};
            tcsr_pkg::REG_STEP:             prdata = {16'd0, cfg_reg.step_mv};
            tcsr_pkg::REG_INITIAL_SETPOINT: prdata = {16'd0, init_sp_reg};
            tcsr_pkg::REG_STARTUP:          prdata = cfg_reg.startup_ms;
            tcsr_pkg::REG_TIMEOUT:          prdata = cfg_reg.timeout_ms;
            default:                        prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

    // the initial setpoint write also reloads the live setpoint
    assign sp_load.load  = wr_en && (idx == tcsr_pkg::REG_INITIAL_SETPOINT);
    assign sp_load.value = pwdata[15:0];

endmodule

`default_nettype wire

>>> rtl/core/tcsr_step_core.sv
`default_nettype none

module tcsr_step_core (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_valid,
    input  wire tcsr_pkg::in_item_t      in_item,
    output logic                         take,
    input  wire tcsr_pkg::cfg_t          cfg,
    input  wire tcsr_pkg::sp_load_t      sp_load,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output tcsr_pkg::out_item_t          m_data
);

    logic [15:0]             setpoint_reg, setpoint_next;
    logic                    stopped_reg, stopped_next;
    tcsr_pkg::cycle_status_t final_status_reg, final_status_next;
    logic                    m_valid_reg;
    tcsr_pkg::out_item_t     m_data_reg, m_data_next;

    logic        in_startup, timed_out, is_done, over_current, too_high, too_low;
    logic [16:0] band_hi;
    logic [15:0] sp_dn, band_lo;
    logic [16:0] sp_sum;
    logic [15:0] sp_upv;

    assign take = in_valid && (!m_valid_reg || m_ready);

    always_comb begin
        in_startup   = in_item.elapsed_ms < cfg.startup_ms;
        timed_out    = in_item.elapsed_ms >= cfg.timeout_ms;
        is_done      = !in_startup && (in_item.charge_current_ma <= cfg.target_current_ma);
        over_current = in_item.charge_current_ma > cfg.max_current_ma;
        band_hi      = {1'b0, cfg.target_voltage_mv} + {1'b0, cfg.hysteresis_mv};
        band_lo      = cfg.target_voltage_mv - cfg.hysteresis_mv;
        too_high     = {1'b0, in_item.battery_voltage_mv} > band_hi;
        // a lower band edge below zero never asks for a step up
        too_low      = (cfg.hysteresis_mv <= cfg.target_voltage_mv) &&
                       (in_item.battery_voltage_mv < band_lo);
        sp_dn        = (cfg.step_mv >= setpoint_reg) ? 16'd0 : setpoint_reg - cfg.step_mv;
        sp_sum       = {1'b0, setpoint_reg} + {1'b0, cfg.step_mv};
        sp_upv       = sp_sum[16] ? 16'hFFFF : sp_sum[15:0];
    end

    always_comb begin
        setpoint_next     = setpoint_reg;
        stopped_next      = stopped_reg;
        final_status_next = final_status_reg;
        m_data_next.cycle_status     = final_status_reg;
        m_data_next.setpoint_written = 1'b0;
        if (!stopped_reg) begin
            m_data_next.cycle_status = in_startup ? tcsr_pkg::ST_STARTUP
                                                  : tcsr_pkg::ST_RUNNING;
            if (timed_out) begin
                stopped_next             = 1'b1;
                final_status_next        = tcsr_pkg::ST_TIMEOUT;
                m_data_next.cycle_status = tcsr_pkg::ST_TIMEOUT;
            end else if (is_done) begin
                stopped_next             = 1'b1;
                final_status_next        = tcsr_pkg::ST_DONE;
                m_data_next.cycle_status = tcsr_pkg::ST_DONE;
            end else if (over_current || too_high) begin
                setpoint_next                = sp_dn;
                m_data_next.setpoint_written = 1'b1;
            end else if (too_low) begin
                setpoint_next                = sp_upv;
                m_data_next.setpoint_written = 1'b1;
            end
        end
        m_data_next.setpoint_mv  = setpoint_next;
        m_data_next.regulator_on = !stopped_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg     <= tcsr_pkg::RST_INITIAL_SETPOINT;
            stopped_reg      <= 1'b0;
            final_status_reg <= tcsr_pkg::ST_STARTUP;
            m_valid_reg      <= 1'b0;
        end else begin
            if (sp_load.load) begin
                setpoint_reg <= sp_load.value;
            end else if (take) begin
                setpoint_reg <= setpoint_next;
            end
            if (take) begin
                stopped_reg      <= stopped_next;
                final_status_reg <= final_status_next;
                m_valid_reg      <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTH
    a_stop_latches: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |=> stopped_reg)
        else $error("stop latch released without reset");

    a_stopped_setpoint_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (stopped_reg && !sp_load.load) |=> $stable(setpoint_reg))
        else $error("setpoint moved after stop");

    a_off_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.regulator_on) |-> !m_data.setpoint_written)
        else $error("setpoint written while regulator off");

    a_final_status_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.cycle_status == tcsr_pkg::ST_TIMEOUT ||
                     m_data.cycle_status == tcsr_pkg::ST_DONE)) |-> !m_data.regulator_on)
        else $error("final status with regulator on");
`endif

endmodule

`default_nettype wire

>>> rtl/core/topping_charge_step_regulator.sv
// Channel   Ports                              Dir   Transfer when
// input     s_valid s_ready s_data             in    s_valid && s_ready
// result    m_valid m_ready m_data             out   m_valid && m_ready
// config    psel penable pwrite paddr pwdata   in    psel && penable && pwrite (pready = 1)
//
// One item per cycle sustained while the result is not stalled; a result passes
// through the input register, then the step logic into the result register.
// The setpoint and stop latch update as an item moves into the result register.
// A stalled result holds the result register; the input register keeps
// accepting while it is empty or moving on. Reset is synchronous, active low.
`default_nettype none

module topping_charge_step_regulator (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire tcsr_pkg::in_item_t          s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output tcsr_pkg::out_item_t              m_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tcsr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);

    tcsr_pkg::cfg_t     cfg;
    tcsr_pkg::sp_load_t sp_load;
    tcsr_pkg::in_item_t in_item_reg;
    logic               in_valid_reg;
    logic               take;

    assign s_ready = !in_valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    tcsr_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .sp_load (sp_load)
    );

    tcsr_step_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_valid_reg),
        .in_item  (in_item_reg),
        .take     (take),
        .cfg      (cfg),
        .sp_load  (sp_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire
